FILE: hdl/bmic_pkg.sv
// Shared widths, defaults and request codes for the budget item counter.
package bmic_pkg;

    localparam int PRICE_W         = 32;
    localparam int BUDGET_W        = 60;
    localparam int MAX_ITEMS_DEF   = 4096;
    localparam int IN_TDATA_W      = ((PRICE_W + BUDGET_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

endpackage

FILE: hdl/bmic_ram.sv
// Simple dual-port catalogue memory with one write port and a registered read port.
module bmic_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 76
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/budget_max_item_count.sv
// Top level of the budget item counter: sorted price catalogue with prefix-sum queries.
//
//  Channel | Direction | Handshake            | Contents
//  --------+-----------+----------------------+--------------------------------------------
//  s_      | in        | s_tvalid / s_tready  | tuser: req_type; tdata: item_price, budget
//  m_      | out       | m_tvalid / m_tready  | tuser: catalogue_overflow; tdata: crate_count
//
// A query runs a bitwise binary search over the running sums, with at most one catalogue
// memory read per step, and then loads the result into the output register.
// A load finds its slot by the same search over prices, then moves every entry at or above
// the slot up by one, reading them and the entry below the slot through the single memory
// read port.
// Reset clears the entry count, overflow flag, state and valid flags, not the memory.
// A held result on m_ does not block loads; a following query waits until it is taken.
module budget_max_item_count
    import bmic_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
    localparam int OUT_W    = ((CNT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input transfers.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [31:0] item_price, [91:32] query_budget
    input  logic                  s_tuser,   // [0] req_type
    // Result transfers.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [CNT_W-1:0] crate_count
    output logic                  m_tuser    // [0] catalogue_overflow
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int SUM_W = PRICE_W + $clog2(MAX_ITEMS);
    localparam int DW    = PRICE_W + SUM_W;

    localparam logic [CNT_W-1:0] TOP_BIT   = CNT_W'(1) << (CNT_W - 1);
    localparam logic [AW-1:0]    TOP_ADDR  = AW'(TOP_BIT - CNT_W'(1));
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ITEMS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE0,
        ST_EMIT
    } state_t;

    state_t               state_reg,   state_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic                 ovf_reg,     ovf_next;
    logic                 query_reg,   query_next;
    logic [PRICE_W-1:0]   price_reg,   price_next;
    logic [BUDGET_W-1:0]  budget_reg,  budget_next;
    logic [CNT_W-1:0]     pos_reg,     pos_next;
    logic [CNT_W-1:0]     bit_reg,     bit_next;
    logic                 cand_ok_reg, cand_ok_next;
    logic [AW-1:0]        last_reg,    last_next;
    logic [AW-1:0]        sh_addr_reg, sh_addr_next;
    logic                 sh_rd_reg,   sh_rd_next;
    logic                 wr_vld_reg,  wr_vld_next;
    logic [AW-1:0]        wr_src_reg,  wr_src_next;
    logic                 m_vld_reg,   m_vld_next;
    logic [CNT_W-1:0]     m_cnt_reg,   m_cnt_next;
    logic                 m_ovf_reg,   m_ovf_next;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [DW-1:0]        rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    logic [PRICE_W-1:0]   rd_price;
    logic [SUM_W-1:0]     rd_sum;
    logic                 s_acc;
    logic                 key_le;
    logic [CNT_W-1:0]     cand;
    logic [CNT_W-1:0]     pos_new;
    logic [CNT_W-1:0]     bit_new;
    logic [CNT_W-1:0]     cand_new;

    // Each entry holds its price in the upper bits and its running sum below.
    bmic_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_price = rd_data[DW-1 -: PRICE_W];
    assign rd_sum   = rd_data[SUM_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = OUT_W'(m_cnt_reg);
    assign m_tuser  = m_ovf_reg;

    // Search step: the candidate count pos|bit is taken when its last entry still fits.
    assign cand     = pos_reg | bit_reg;
    assign key_le   = query_reg ? (BUDGET_W'(rd_sum) <= budget_reg) : (rd_price <= price_reg);
    assign pos_new  = (cand_ok_reg && key_le) ? cand : pos_reg;
    assign bit_new  = bit_reg >> 1;
    assign cand_new = pos_new | bit_new;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        query_next   = query_reg;
        price_next   = price_reg;
        budget_next  = budget_reg;
        pos_next     = pos_reg;
        bit_next     = bit_reg;
        cand_ok_next = cand_ok_reg;
        last_next    = last_reg;
        sh_addr_next = sh_addr_reg;
        sh_rd_next   = sh_rd_reg;
        wr_vld_next  = 1'b0;
        wr_src_next  = wr_src_reg;
        m_vld_next   = m_vld_reg && !m_tready;
        m_cnt_next   = m_cnt_reg;
        m_ovf_next   = m_ovf_reg;
        rd_en        = 1'b0;
        rd_addr      = TOP_ADDR;
        wr_en        = 1'b0;
        wr_addr      = wr_src_reg + AW'(1);
        wr_data      = {price_reg, rd_sum + SUM_W'(price_reg)};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (req_t'(s_tuser) == REQ_LOAD && count_reg == FULL_CNT) begin
                        ovf_next = 1'b1;
                    end else begin
                        query_next   = (req_t'(s_tuser) == REQ_QUERY);
                        price_next   = s_tdata[PRICE_W-1:0];
                        budget_next  = s_tdata[PRICE_W +: BUDGET_W];
                        pos_next     = '0;
                        bit_next     = TOP_BIT;
                        cand_ok_next = (TOP_BIT <= count_reg);
                        rd_en        = (TOP_BIT <= count_reg);
                        rd_addr      = TOP_ADDR;
                        state_next   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                pos_next = pos_new;
                bit_next = bit_new;
                if (bit_reg[0]) begin
                    if (query_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        last_next    = (pos_new == '0) ? '0 : AW'(pos_new - CNT_W'(1));
                        sh_addr_next = AW'(count_reg - CNT_W'(1));
                        sh_rd_next   = (count_reg != '0);
                        state_next   = (count_reg == '0) ? ST_PLACE0 : ST_SHIFT;
                    end
                end else begin
                    cand_ok_next = (cand_new <= count_reg);
                    rd_en        = (cand_new <= count_reg);
                    rd_addr      = AW'(pos_new | (bit_new - CNT_W'(1)));
                end
            end
            ST_SHIFT: begin
                // Reads walk down from the top entry; each one is written one slot higher in the
                // following cycle. The entry just below the slot supplies the new price's sum.
                if (sh_rd_reg) begin
                    rd_en       = 1'b1;
                    rd_addr     = sh_addr_reg;
                    wr_vld_next = 1'b1;
                    wr_src_next = sh_addr_reg;
                    if (sh_addr_reg == last_reg) begin
                        sh_rd_next = 1'b0;
                    end else begin
                        sh_addr_next = sh_addr_reg - AW'(1);
                    end
                end
                if (wr_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = wr_src_reg + AW'(1);
                    wr_data = {(CNT_W'(wr_src_reg) >= pos_reg) ? rd_price : price_reg,
                               rd_sum + SUM_W'(price_reg)};
                    if (!sh_rd_reg) begin
                        if (pos_reg == '0) begin
                            state_next = ST_PLACE0;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_PLACE0: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {price_reg, SUM_W'(price_reg)};
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_next = 1'b1;
                    m_cnt_next = pos_reg;
                    m_ovf_next = ovf_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            query_reg   <= 1'b0;
            cand_ok_reg <= 1'b0;
            sh_rd_reg   <= 1'b0;
            wr_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            query_reg   <= query_next;
            cand_ok_reg <= cand_ok_next;
            sh_rd_reg   <= sh_rd_next;
            wr_vld_reg  <= wr_vld_next;
            m_vld_reg   <= m_vld_next;
            price_reg   <= price_next;
            budget_reg  <= budget_next;
            pos_reg     <= pos_next;
            bit_reg     <= bit_next;
            last_reg    <= last_next;
            sh_addr_reg <= sh_addr_next;
            wr_src_reg  <= wr_src_next;
            m_cnt_reg   <= m_cnt_next;
            m_ovf_reg   <= m_ovf_next;
        end
    end

`ifndef SYNTHESIS
    // The catalogue never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds catalogue size");

    // Once a load has been dropped, the flag stays set until reset.
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared without reset");

    // A dropped load changes nothing but the overflow flag.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == REQ_LOAD && count_reg == FULL_CNT)
        |=> (ovf_reg && $stable(count_reg) && state_reg == ST_IDLE))
        else $error("load into a full catalogue was not dropped");

    // A pending result never counts more entries than are stored.
    a_result_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg |-> (m_cnt_reg <= count_reg))
        else $error("result count exceeds stored entries");

    // While entries move up, the write never lands on the entry being read.
    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same catalogue entry in one cycle");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the sorted price catalogue and budget count block.
`timescale 1ns / 1ps

module tb;
    import bmic_pkg::*;

    // The block runs at its default size, so the count field is 13 bits wide.
    // It also shows the 4096 boundary of crate_count and the full 44-bit running sums.
    localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int OUT_W       = ((CNT_W + 7) / 8) * 8;
    // The slowest correct step is a load that moves every stored entry up by one slot.
    // The quiet-cycle limit is that time taken many times over.
    localparam int LOAD_WORST  = MAX_ITEMS + CNT_W + 3;
    localparam int QUIET_LIMIT = 20 * (LOAD_WORST + 64);
    localparam int RANDOM_REQS = 450;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;   // [31:0] item_price, [91:32] query_budget
    logic                  s_tuser  = 1'b0; // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;         // [CNT_W-1:0] crate_count
    logic                  m_tuser;         // [0] catalogue_overflow

    budget_max_item_count #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // One answer that a query is predicted to return.
    typedef struct {
        logic [CNT_W-1:0] crates;
        logic             overflow;
    } answer_t;

    // The testbench's own copy of the block state. The prices are kept in ascending order.
    // Prefix sums are formed on demand in 64 bits, so they cannot wrap.
    logic [PRICE_W-1:0] shelf_prices[$];
    logic               drop_seen = 1'b0;
    answer_t            pending_answers[$];

    // Both sides idle in random bursts only while this is set.
    bit idle_on = 1'b1;

    int unsigned mismatches   = 0;
    int unsigned loads_sent   = 0;
    int unsigned loads_lost   = 0;
    int unsigned queries_sent = 0;
    int unsigned answers_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The first index whose price is strictly greater than p. A new price goes after any
    // equal prices that are already stored.
    function automatic int slot_after(input logic [PRICE_W-1:0] p);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shelf_prices.size();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (shelf_prices[mid] > p) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    // The sum of the j cheapest stored prices.
    function automatic logic [63:0] cheapest_sum(input int j);
        logic [63:0] acc;
        acc = '0;
        for (int k = 0; k < j && k < shelf_prices.size(); k++) acc += shelf_prices[k];
        return acc;
    endfunction

    // The greedy count: it buys the cheapest crates first while the budget still covers them.
    function automatic int crates_affordable(input logic [BUDGET_W-1:0] budget);
        logic [63:0] acc;
        int          n;
        acc = '0;
        n   = 0;
        foreach (shelf_prices[k]) begin
            acc += shelf_prices[k];
            if (acc > {4'b0, budget}) break;
            n++;
        end
        return n;
    endfunction

    // Sends one request and applies it to the copy of the state when the transfer completes.
    // Valid stays high after the transfer. The next call lowers it only when it opens a
    // gap, so s_tvalid never gets two nonblocking assignments in one step.
    task automatic send_request(input req_t kind, input logic [PRICE_W-1:0] price,
                                input logic [BUDGET_W-1:0] budget);
        logic [IN_TDATA_W-1:0] word;
        answer_t               ans;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        word = '0;
        word[PRICE_W-1:0]                = price;
        word[PRICE_W+BUDGET_W-1:PRICE_W] = budget;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        if (kind == REQ_LOAD) begin
            loads_sent++;
            if (shelf_prices.size() >= MAX_ITEMS) begin
                drop_seen = 1'b1;
                loads_lost++;
            end else begin
                shelf_prices.insert(slot_after(price), price);
            end
        end else begin
            queries_sent++;
            ans.crates   = CNT_W'(crates_affordable(budget));
            ans.overflow = drop_seen;
            pending_answers.push_back(ans);
        end
    endtask

    // Stops sending until every predicted answer has arrived.
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // Picks a budget near the prefix sum of a random count. Such a budget hits the count
    // exactly, falls one short of it, or passes it by one.
    function automatic logic [BUDGET_W-1:0] budget_near_sum();
        logic [63:0] s;
        s = cheapest_sum($urandom_range(0, shelf_prices.size()));
        case ($urandom_range(0, 2))
            0: s = s - 1;
            1: s = s + 1;
            default: ;
        endcase
        return s[BUDGET_W-1:0];
    endfunction

    function automatic logic [BUDGET_W-1:0] random_budget();
        logic [63:0] r;
        int          pick;
        pick = $urandom_range(0, 19);
        r    = {$urandom, $urandom};
        if (pick < 10) return budget_near_sum();
        else if (pick < 13) return r[BUDGET_W-1:0];
        else if (pick < 15) return '0;
        else if (pick < 17) return '1;
        else return BUDGET_W'(r % (cheapest_sum(shelf_prices.size()) + 2));
    endfunction

    // Small prices repeat often, which tests how equal prices are placed.
    // Extreme prices test the widest running sums.
    function automatic logic [PRICE_W-1:0] random_price();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return PRICE_W'($urandom_range(0, 20));
        else if (pick < 6) return $urandom;
        else if (pick < 7) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        else return PRICE_W'($urandom_range(0, 65535));
    endfunction

    // Queries against an empty catalogue must answer zero, whatever the budget.
    task automatic test_empty_catalogue();
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_QUERY, '1, '1);
        send_request(REQ_QUERY, $urandom, BUDGET_W'({$urandom, $urandom}));
    endtask

    // Extreme prices, zero prices, equal prices, and budgets on both sides of several
    // prefix sums.
    task automatic test_directed_prices();
        send_request(REQ_LOAD, '0, '1);
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_LOAD, '1, '0);
        send_request(REQ_LOAD, 32'd5, '0);
        send_request(REQ_LOAD, 32'd5, '0);
        send_request(REQ_LOAD, 32'd3, '0);
        send_request(REQ_LOAD, 32'h8000_0000, '0);
        send_request(REQ_LOAD, 32'd1, '0);
        send_request(REQ_QUERY, '0, 60'd0);
        send_request(REQ_QUERY, '0, 60'd3);
        send_request(REQ_QUERY, '0, 60'd4);
        send_request(REQ_QUERY, '0, 60'd13);
        send_request(REQ_QUERY, '0, 60'd14);
        send_request(REQ_QUERY, '0, 60'h0_8000_000D);
        send_request(REQ_QUERY, '0, BUDGET_W'(cheapest_sum(7)));
        send_request(REQ_QUERY, '0, BUDGET_W'(cheapest_sum(7) - 1));
        send_request(REQ_QUERY, '0, '1);
    endtask

    // Random loads and queries interleaved. A mid stretch runs without any idling, and
    // the sender drains all answers every so often.
    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++) begin
            idle_on = !(i >= n / 2 && i < n / 2 + 60);
            if (i % 90 == 89) drain_answers();
            if ($urandom_range(0, 99) < 55) send_request(REQ_LOAD, random_price(), '0);
            else send_request(REQ_QUERY, $urandom, random_budget());
        end
        idle_on = 1'b1;
    endtask

    // Fills the catalogue with the largest price. An equal price goes after its peers, so
    // these loads move nothing. Loads into the full catalogue must then be dropped and
    // flagged. The whole task runs without idling.
    task automatic test_full_catalogue();
        idle_on = 1'b0;
        while (shelf_prices.size() < MAX_ITEMS) begin
            send_request(REQ_LOAD, '1, '0);
            if (shelf_prices.size() % 1024 == 0)
                send_request(REQ_QUERY, '0, random_budget());
        end
        send_request(REQ_QUERY, '0, '1);
        send_request(REQ_LOAD, '0, '0);
        send_request(REQ_QUERY, '0, '1);
        send_request(REQ_QUERY, '0, '0);
        send_request(REQ_LOAD, $urandom, '0);
        send_request(REQ_LOAD, '1, '0);
        for (int i = 0; i < 8; i++) send_request(REQ_QUERY, $urandom, random_budget());
    endtask

    // Output side: random stall bursts while idling is on. Otherwise it is ready once any burst in progress has ended.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checks each result transfer against the oldest predicted answer.
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result count=%0d overflow=%0b",
                             m_tdata[CNT_W-1:0], m_tuser);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[CNT_W-1:0] !== want.crates || m_tuser !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d count exp %0d got %0d, overflow exp %0b got %0b",
                                 answers_seen, want.crates, m_tdata[CNT_W-1:0],
                                 want.overflow, m_tuser);
                end
            end
        end
    end

    // Ends the run if nothing moves on either channel for far longer than any correct step.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_catalogue();
        test_directed_prices();
        test_random_traffic(RANDOM_REQS);
        test_full_catalogue();

        // Let the last answers arrive, then give a load time to finish in case it produces
        // something it should not.
        drain_answers();
        repeat (LOAD_WORST + 64) @(posedge aclk);

        if (pending_answers.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d predicted results never arrived", pending_answers.size());
        end
        $display("Sent %0d loads (%0d dropped at a full catalogue) and %0d budget queries.",
                 loads_sent, loads_lost, queries_sent);
        $display("Compared %0d results; the catalogue reached %0d entries.",
                 answers_seen, shelf_prices.size());
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/bmic_pkg.sv
hdl/bmic_ram.sv
hdl/budget_max_item_count.sv
tb/sv/tb.sv
